[hdl/kssc_pkg.sv]
// Shared constants and types for the keyword shift substitution cipher.
package kssc_pkg;

    localparam int ALPHA_SIZE = 26;
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 3;
    localparam int SHIFT_W    = 5;

    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_KEY    = 3'd1,
        OP_FINISH = 3'd2,
        OP_ENC    = 3'd3,
        OP_DEC    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_COPY,
        FS_FILL
    } t_fin_state;

endpackage

[hdl/kssc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/keyword_shift_substitution_cipher.sv]
// Keyword substitution cipher with alphabet rotation, top level.
// Encrypt/decrypt: the input beat goes through the read stage (table read) and then the output
// register; one byte per cycle sustained while the output is not stalled. Clear, keyword and
// unknown ops do not hold off the input. Finish: input held off while the table RAMs
// are rewritten, at most one cipher and one inverse entry per cycle.
// Reset clears the keyword state and shift; tables read as identity until the first finish.
module keyword_shift_substitution_cipher
    import kssc_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHA_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SHIFT_W-1:0] i_cfg_data,     // shift_amount
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [OP_W-1:0]    s_axis_tuser,   // [2:0] op
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [BYTE_W-1:0]  m_axis_tdata    // [7:0] out_byte
);

    localparam int LW = $clog2(ALPHABET_SIZE);
    localparam int CW = $clog2(ALPHABET_SIZE + 1);
    localparam logic [LW:0]       SIZE_X   = (LW+1)'(ALPHABET_SIZE);
    localparam logic [CW-1:0]     SIZE_C   = CW'(ALPHABET_SIZE);
    localparam logic [LW-1:0]     LAST_L   = LW'(ALPHABET_SIZE - 1);
    localparam logic [BYTE_W-1:0] LOWER_Z  = BYTE_W'(CH_LOWER_A + ALPHABET_SIZE - 1);
    localparam logic [BYTE_W-1:0] UPPER_Z  = BYTE_W'(CH_UPPER_A + ALPHABET_SIZE - 1);

    // configuration
    logic [SHIFT_W-1:0] r_shift;
    logic [LW:0]        shift_x;
    logic [LW-1:0]      shift_m;

    // keyword state
    logic [ALPHABET_SIZE-1:0] r_used;
    logic [CW-1:0]            r_placed;
    logic [LW-1:0]            r_build [ALPHABET_SIZE];

    // finish walk
    t_fin_state  r_state, n_state;
    logic [CW-1:0] r_pos;
    logic [LW-1:0] r_ltr;
    logic          r_tbl_ok;
    logic          fin_last;
    logic          cip_we, inv_we;
    logic [LW-1:0] cip_waddr, cip_wdata, inv_waddr, inv_wdata;
    logic [LW-1:0] build_cur;

    // input decode
    t_op           op;
    logic          is_lower, is_upper, is_letter;
    logic [LW-1:0] idx;
    logic          acc, key_take, take_rd;
    logic [LW:0]   enc_sum;
    logic [LW-1:0] enc_addr;

    // read stage
    logic              r_rd_vld, r_rd_pass, r_rd_upper, r_rd_dec, r_rd_ident;
    logic [LW-1:0]     r_rd_addr;
    logic [BYTE_W-1:0] r_rd_byte;
    logic [LW-1:0]     cip_rdata, inv_rdata, tbl_val, res_l;
    logic [BYTE_W-1:0] res_byte;
    logic              adv;

    // output register
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;

    assign shift_x = (LW+1)'(r_shift);
    assign shift_m = (shift_x >= SIZE_X) ? LW'(shift_x - SIZE_X) : LW'(shift_x);

    assign op        = t_op'(s_axis_tuser);
    assign is_lower  = (s_axis_tdata >= CH_LOWER_A) && (s_axis_tdata <= LOWER_Z);
    assign is_upper  = (s_axis_tdata >= CH_UPPER_A) && (s_axis_tdata <= UPPER_Z);
    assign is_letter = is_lower || is_upper;
    assign idx       = is_lower ? LW'(s_axis_tdata - CH_LOWER_A)
                                : LW'(s_axis_tdata - CH_UPPER_A);

    assign enc_sum  = (LW+1)'(idx) + (LW+1)'(shift_m);
    assign enc_addr = (enc_sum >= SIZE_X) ? LW'(enc_sum - SIZE_X) : LW'(enc_sum);

    assign adv           = r_rd_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = (r_state == FS_IDLE) && (!r_rd_vld || adv);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign take_rd       = acc && ((op == OP_ENC) || (op == OP_DEC));
    assign key_take      = acc && (op == OP_KEY) && is_letter && !r_used[idx]
                           && (r_placed < SIZE_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
        end else if (i_cfg_we) begin
            r_shift <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_placed <= '0;
        end else if (acc && (op == OP_CLEAR)) begin
            r_used   <= '0;
            r_placed <= '0;
        end else if (key_take) begin
            r_used[idx] <= 1'b1;
            r_placed    <= r_placed + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_take) begin
            r_build[r_placed[LW-1:0]] <= idx;
        end
    end

    // finish walk: copy keyword letters, then append the unused ones
    assign build_cur = r_build[r_pos[LW-1:0]];
    assign fin_last  = (r_ltr == LAST_L);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (acc && (op == OP_FINISH)) begin
                    n_state = FS_COPY;
                end
            end
            FS_COPY: begin
                if (r_pos == r_placed) begin
                    n_state = FS_FILL;
                end
            end
            FS_FILL: begin
                if (fin_last) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        cip_we    = 1'b0;
        inv_we    = 1'b0;
        cip_waddr = r_pos[LW-1:0];
        cip_wdata = r_ltr;
        inv_waddr = r_ltr;
        inv_wdata = r_pos[LW-1:0];
        unique case (r_state)
            FS_COPY: begin
                cip_we    = (r_pos < r_placed);
                inv_we    = (r_pos < r_placed);
                cip_wdata = build_cur;
                inv_waddr = build_cur;
            end
            FS_FILL: begin
                cip_we = !r_used[r_ltr];
                inv_we = !r_used[r_ltr];
            end
            default: begin
                cip_we = 1'b0;
                inv_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_IDLE;
            r_pos    <= '0;
            r_ltr    <= '0;
            r_tbl_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                FS_IDLE: begin
                    r_pos <= '0;
                    r_ltr <= '0;
                end
                FS_COPY: begin
                    if (r_pos < r_placed) begin
                        r_pos <= r_pos + CW'(1);
                    end
                end
                FS_FILL: begin
                    if (!r_used[r_ltr]) begin
                        r_pos <= r_pos + CW'(1);
                    end
                    r_ltr <= r_ltr + LW'(1);
                    if (fin_last) begin
                        r_tbl_ok <= 1'b1;
                    end
                end
                default: begin
                    r_pos <= '0;
                    r_ltr <= '0;
                end
            endcase
        end
    end

    kssc_ram #(
        .WIDTH (LW),
        .DEPTH (ALPHABET_SIZE)
    ) u_cipher_ram (
        .i_clk   (i_clk),
        .i_we    (cip_we),
        .i_waddr (cip_waddr),
        .i_wdata (cip_wdata),
        .i_re    (take_rd && (op == OP_ENC) && is_letter),
        .i_raddr (enc_addr),
        .o_rdata (cip_rdata)
    );

    kssc_ram #(
        .WIDTH (LW),
        .DEPTH (ALPHABET_SIZE)
    ) u_inverse_ram (
        .i_clk   (i_clk),
        .i_we    (inv_we),
        .i_waddr (inv_waddr),
        .i_wdata (inv_wdata),
        .i_re    (take_rd && (op == OP_DEC) && is_letter),
        .i_raddr (idx),
        .o_rdata (inv_rdata)
    );

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (take_rd) begin
            r_rd_vld <= 1'b1;
        end else if (adv) begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_rd) begin
            r_rd_pass  <= !is_letter;
            r_rd_upper <= is_upper;
            r_rd_dec   <= (op == OP_DEC);
            r_rd_ident <= !r_tbl_ok;
            r_rd_addr  <= (op == OP_DEC) ? idx : enc_addr;
            r_rd_byte  <= s_axis_tdata;
        end
    end

    assign tbl_val = r_rd_ident ? r_rd_addr : (r_rd_dec ? inv_rdata : cip_rdata);

    always_comb begin
        if (!r_rd_dec) begin
            res_l = tbl_val;
        end else if (tbl_val >= shift_m) begin
            res_l = tbl_val - shift_m;
        end else begin
            res_l = LW'((LW+1)'(tbl_val) + SIZE_X - (LW+1)'(shift_m));
        end
    end

    assign res_byte = r_rd_pass ? r_rd_byte
                                : ((r_rd_upper ? CH_UPPER_A : CH_LOWER_A) + BYTE_W'(res_l));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= res_byte;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;

endmodule

[sim/keyword_shift_substitution_cipher_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the keyword shift substitution cipher top level.
module keyword_shift_substitution_cipher_tb;
    import kssc_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYCLES  = 7;
    localparam int SETTLE_CYC  = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1560;
    localparam int MAX_REPORTS = 10;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [SHIFT_W-1:0] i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic [OP_W-1:0]    s_axis_tuser  = '0;   // [2:0] op
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]  m_axis_tdata;         // [7:0] out_byte

    // predicted cipher state
    logic [4:0]          cipher_tab [ALPHA_SIZE];
    logic [4:0]          inverse_tab[ALPHA_SIZE];
    logic [4:0]          key_seq    [ALPHA_SIZE];
    logic [ALPHA_SIZE-1:0] key_used;
    int                  key_count;
    logic [SHIFT_W-1:0]  shift_val;

    logic [BYTE_W-1:0]   expected_bytes[$];
    int                  err_count   = 0;
    int                  beats_sent  = 0;
    int                  cycle_count = 0;
    int                  rx_hold     = 0;
    bit                  no_gaps     = 1'b0;

    keyword_shift_substitution_cipher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic void reset_cipher_state();
        for (int i = 0; i < ALPHA_SIZE; i++) begin
            cipher_tab[i]  = 5'(i);
            inverse_tab[i] = 5'(i);
            key_seq[i]     = '0;
        end
        key_used  = '0;
        key_count = 0;
        shift_val = '0;
    endfunction

    // -1 for anything that is not an ASCII letter
    function automatic int letter_index(input logic [BYTE_W-1:0] b);
        if (b >= CH_LOWER_A && int'(b) < int'(CH_LOWER_A) + ALPHA_SIZE)
            return int'(b) - int'(CH_LOWER_A);
        if (b >= CH_UPPER_A && int'(b) < int'(CH_UPPER_A) + ALPHA_SIZE)
            return int'(b) - int'(CH_UPPER_A);
        return -1;
    endfunction

    function automatic void apply_cipher_op(input logic [OP_W-1:0] op,
                                            input logic [BYTE_W-1:0] b);
        int idx;
        int n;
        int sh;
        int r;
        logic [BYTE_W-1:0] base;
        idx  = letter_index(b);
        base = (b >= CH_LOWER_A) ? CH_LOWER_A : CH_UPPER_A;
        sh   = int'(shift_val) % ALPHA_SIZE;
        case (op)
            OP_CLEAR: begin
                key_used  = '0;
                key_count = 0;
            end
            OP_KEY: begin
                if (idx >= 0 && !key_used[idx] && key_count < ALPHA_SIZE) begin
                    key_seq[key_count] = 5'(idx);
                    key_used[idx]      = 1'b1;
                    key_count++;
                end
            end
            OP_FINISH: begin
                n = key_count;
                for (int i = 0; i < n; i++)
                    cipher_tab[i] = key_seq[i];
                for (int i = 0; i < ALPHA_SIZE; i++) begin
                    if (!key_used[i] && n < ALPHA_SIZE) begin
                        cipher_tab[n] = 5'(i);
                        n++;
                    end
                end
                for (int i = 0; i < ALPHA_SIZE; i++)
                    inverse_tab[cipher_tab[i]] = 5'(i);
            end
            OP_ENC: begin
                if (idx < 0)
                    expected_bytes.push_back(b);
                else
                    expected_bytes.push_back(base + 8'(cipher_tab[(idx + sh) % ALPHA_SIZE]));
            end
            OP_DEC: begin
                if (idx < 0) begin
                    expected_bytes.push_back(b);
                end else begin
                    r = (int'(inverse_tab[idx]) + ALPHA_SIZE - sh) % ALPHA_SIZE;
                    expected_bytes.push_back(base + 8'(r));
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_letter();
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A)
               + 8'($urandom_range(0, ALPHA_SIZE - 1));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_text_byte();
        return ($urandom_range(0, 9) < 7) ? rand_letter() : 8'($urandom_range(0, 255));
    endfunction

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        apply_cipher_op(op, b);
        beats_sent++;
    endtask

    // hold the sender until every result is out and a finish pass has had time to end
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_shift(input logic [SHIFT_W-1:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        shift_val = val;
    endtask

    task automatic test_identity_tables();
        send_beat(OP_ENC, "a");
        send_beat(OP_DEC, "Z");
        send_beat(OP_ENC, 8'h00);
        send_beat(OP_DEC, 8'hFF);
    endtask

    task automatic test_spare_ops();
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            send_beat(OP_W'(op), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_keyword_alphabet();
        string kw;
        kw = "Kk3Ey";
        send_beat(OP_CLEAR, 8'h00);
        for (int i = 0; i < kw.len(); i++)
            send_beat(OP_KEY, kw[i]);
        send_beat(OP_KEY, 8'hE1);       // letter with top bit set: dropped
        send_beat(OP_KEY, "E");
        send_beat(OP_ENC, "c");         // still the old alphabet
        send_beat(OP_FINISH, 8'hA5);
        send_beat(OP_ENC, "h");
        send_beat(OP_DEC, "K");
        send_beat(OP_ENC, "~");
        send_beat(OP_KEY, "Q");         // extends the same keyword
        send_beat(OP_FINISH, 8'h00);
        send_beat(OP_ENC, "z");
    endtask

    task automatic test_shift_extremes();
        logic [SHIFT_W-1:0] vals[3];
        vals = '{5'd25, 5'd26, 5'd31};
        foreach (vals[k]) begin
            write_shift(vals[k]);
            send_beat(OP_ENC, "y");
            send_beat(OP_DEC, "B");
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        int j;
        logic [4:0] order[ALPHA_SIZE];
        logic [4:0] t;
        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            case (phase % 8)
                0: write_shift(5'd0);
                1: write_shift(5'd31);
                2: write_shift(5'd25);
                default: write_shift(5'($urandom_range(0, 31)));
            endcase
            no_gaps = (phase % 5 == 4);
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 3) != 0)
                    send_beat(OP_CLEAR, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0) begin
                    for (int i = 0; i < ALPHA_SIZE; i++)
                        order[i] = 5'(i);
                    for (int i = ALPHA_SIZE - 1; i > 0; i--) begin
                        j        = $urandom_range(0, i);
                        t        = order[i];
                        order[i] = order[j];
                        order[j] = t;
                    end
                    for (int i = 0; i < ALPHA_SIZE; i++)
                        send_beat(OP_KEY, ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A)
                                          + 8'(order[i]));
                    repeat ($urandom_range(0, 3)) send_beat(OP_KEY, rand_letter());
                end else begin
                    n = $urandom_range(0, 12);
                    repeat (n)
                        send_beat(OP_KEY, ($urandom_range(0, 6) != 0) ? rand_letter()
                                                                    : 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 9) != 0)
                    send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(20, 60))
                    send_beat($urandom_range(0, 1) ? OP_ENC : OP_DEC, rand_text_byte());
            end else begin
                repeat ($urandom_range(10, 30))
                    send_beat(OP_W'($urandom_range(0, OP_SPARE_HI)), 8'($urandom_range(0, 255)));
            end
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
        end else if (no_gaps || $urandom_range(0, 3) != 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            rx_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin : result_check
        logic [BYTE_W-1:0] want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected out beat: got %h (cycle %0d)", m_axis_tdata, cycle_count);
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("out_byte mismatch: expected %h, got %h (cycle %0d)",
                                 want, m_axis_tdata, cycle_count);
                end
            end
        end
    end

    initial begin
        reset_cipher_state();
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_identity_tables();
        test_spare_ops();
        test_keyword_alphabet();
        test_shift_extremes();
        test_random_traffic();
        wait_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
